>>> rtl/oss_pkg.sv
// Package for the ordered sequence store: widths, codes and item types.
`timescale 1ns / 1ps
`default_nettype none
package oss_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int OP_W     = 3;
  localparam int ST_W     = 3;
  localparam int VAL_W    = 32;

  localparam logic [OP_W-1:0] OP_APPEND      = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE_LAST = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT_AT   = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE_AT   = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE_VAL  = 3'd4;
  localparam logic [OP_W-1:0] OP_FIND        = 3'd5;
  localparam logic [OP_W-1:0] OP_READ_AT     = 3'd6;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [ST_W-1:0] ST_BADPOS   = 3'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]         opcode;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic [3:0]              found_index;
    logic signed [VAL_W-1:0] read_value;
    logic [4:0]              count;
  } rsp_t;

  typedef struct packed {
    logic load_req;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       busy;
    logic [4:0] count;
  } dp_status_t;

endpackage
`default_nettype wire

>>> rtl/oss_ctrl.sv
// Controller for the ordered sequence store: request state and result handshake.
`timescale 1ns / 1ps
`default_nettype none
module oss_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  input  wire oss_pkg::dp_status_t dp_status_i,
  output oss_pkg::ctrl_cmd_t       cmd_o
);
  import oss_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic exec;

  // dp_status_i.busy mirrors an outstanding request held in the datapath
  assign exec = (state_q == S_EXEC) && dp_status_i.busy && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (exec) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = exec | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign cmd_o.load_req = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.exec     = exec;

endmodule
`default_nettype wire

>>> rtl/oss_dp.sv
// Datapath for the ordered sequence store: value cells, count, match and shift logic.
`timescale 1ns / 1ps
`default_nettype none
module oss_dp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire oss_pkg::ctrl_cmd_t cmd_i,
  input  wire oss_pkg::req_t      req_i,
  output oss_pkg::dp_status_t     status_o,
  output oss_pkg::rsp_t           rsp_o
);
  import oss_pkg::*;

  req_t                    req_q;
  rsp_t                    rsp_q, rsp_d;
  logic                    busy_q;
  logic [CNT_W-1:0]        count_q, count_d;
  logic signed [VAL_W-1:0] cells_q [CAPACITY];
  logic signed [VAL_W-1:0] cells_d [CAPACITY];
  logic signed [VAL_W-1:0] ins_src [CAPACITY];
  logic signed [VAL_W-1:0] rem_src [CAPACITY];

  logic                    hit;
  logic [IDX_W-1:0]        hit_idx;
  logic [IDX_W-1:0]        rd_addr;
  logic signed [VAL_W-1:0] rd_val;
  logic                    ins_en, rem_en;
  logic [POS_W-1:0]        ins_pos, rem_pos;
  logic [POS_W-1:0]        n_pos;

  assign n_pos = POS_W'(count_q);

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < count_q) && (cells_q[i] == req_q.value)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    ins_src[0] = req_q.value;
    for (int i = 1; i < CAPACITY; i++) ins_src[i] = cells_q[i-1];
    for (int i = 0; i < CAPACITY - 1; i++) rem_src[i] = cells_q[i+1];
    rem_src[CAPACITY-1] = cells_q[CAPACITY-1];
  end

  assign rd_addr = (req_q.opcode == OP_REMOVE_LAST) ? IDX_W'(count_q - CNT_W'(1))
                                                    : req_q.position[IDX_W-1:0];
  assign rd_val  = cells_q[rd_addr];

  always_comb begin
    rsp_d             = '0;
    rsp_d.status      = ST_OK;
    count_d           = count_q;
    ins_en            = 1'b0;
    rem_en            = 1'b0;
    ins_pos           = req_q.position;
    rem_pos           = req_q.position;
    case (req_q.opcode)
      OP_APPEND: begin
        ins_pos = n_pos;
        if (count_q >= CNT_W'(CAPACITY)) begin
          rsp_d.status = ST_FULL;
        end else begin
          ins_en  = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_REMOVE_LAST: begin
        if (count_q == '0) begin
          rsp_d.status = ST_EMPTY;
        end else begin
          rsp_d.read_value = rd_val;
          count_d          = count_q - CNT_W'(1);
        end
      end
      OP_INSERT_AT: begin
        if (req_q.position > n_pos) begin
          rsp_d.status = ST_BADPOS;
        end else if (count_q >= CNT_W'(CAPACITY)) begin
          rsp_d.status = ST_FULL;
        end else begin
          ins_en  = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_REMOVE_AT: begin
        if (count_q == '0) begin
          rsp_d.status = ST_EMPTY;
        end else if (req_q.position >= n_pos) begin
          rsp_d.status = ST_BADPOS;
        end else begin
          rsp_d.read_value = rd_val;
          rem_en           = 1'b1;
          count_d          = count_q - CNT_W'(1);
        end
      end
      OP_REMOVE_VAL: begin
        rem_pos = POS_W'(hit_idx);
        if (hit) begin
          rsp_d.found_index = 4'(hit_idx);
          rsp_d.read_value  = req_q.value;
          rem_en            = 1'b1;
          count_d           = count_q - CNT_W'(1);
        end else begin
          rsp_d.status = ST_NOTFOUND;
        end
      end
      OP_FIND: begin
        if (hit) begin
          rsp_d.found_index = 4'(hit_idx);
          rsp_d.read_value  = req_q.value;
        end else begin
          rsp_d.status = ST_NOTFOUND;
        end
      end
      OP_READ_AT: begin
        if (req_q.position >= n_pos) rsp_d.status = ST_BADPOS;
        else rsp_d.read_value = rd_val;
      end
      default: ;
    endcase
    rsp_d.count = 5'(count_d);
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_d[i] = cells_q[i];
      if (ins_en) begin
        if (POS_W'(i) == ins_pos) cells_d[i] = req_q.value;
        else if (POS_W'(i) > ins_pos) cells_d[i] = ins_src[i];
      end else if (rem_en) begin
        if (POS_W'(i) >= rem_pos) cells_d[i] = rem_src[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      count_q <= '0;
    end else begin
      if (cmd_i.load_req) busy_q <= 1'b1;
      else if (cmd_i.exec) busy_q <= 1'b0;
      if (cmd_i.exec) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
    if (cmd_i.exec) begin
      rsp_q   <= rsp_d;
      cells_q <= cells_d;
    end
  end

  assign status_o.busy  = busy_q;
  assign status_o.count = 5'(count_q);
  assign rsp_o          = rsp_q;

endmodule
`default_nettype wire

>>> rtl/ordered_sequence_store_top.sv
// Top level of the ordered sequence store: controller and datapath.
// The request register loads when an item is accepted and the result register when the
// request executes, which waits while an earlier result is still held by out_stall_i.
// A new item waits until the last has executed; the cell compare and shift is combinational.
// A waiting result holds off the next execute, not the next accept.
// Reset clears the count and handshake state; value cells are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module ordered_sequence_store_top (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire oss_pkg::req_t  in_item_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output oss_pkg::rsp_t       out_item_o
);
  import oss_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  oss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dp_status_i (dp_status),
    .cmd_o       (cmd)
  );

  oss_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .req_i    (in_item_i),
    .status_o (dp_status),
    .rsp_o    (out_item_o)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item accepted while another is in progress");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_status.count <= 5'(CAPACITY))
    else $error("count above capacity");

  a_result_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result offered without a request in progress");

  a_result_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (out_item_o.count == dp_status.count))
    else $error("result count differs from stored count");
`endif

endmodule
`default_nettype wire
